// File: sv/sca_pkg.sv
`default_nettype none

package sca_pkg;

   // Time base and display mode codes
   localparam int TIME_W = 32;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_ALERT = 2'd1,
      MODE_STALE = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   // Previous mode after reset: not a legal mode, so the first tick is fresh
   localparam logic [2:0] PREV_MODE_RESET = 3'd7;
   localparam logic [7:0] PREV_SEV_RESET  = 8'd255;

   // Redraw gaps and car sizes
   localparam logic [TIME_W-1:0] IDLE_GAP  = TIME_W'(50);
   localparam logic [TIME_W-1:0] STALE_GAP = TIME_W'(200);
   localparam logic [6:0] IDLE_SIZE  = 7'd65;
   localparam logic [6:0] STALE_SIZE = 7'd40;

   // Reciprocals for now mod 3000 (as 8 * 375) and now mod 4000 (as 32 * 125)
   localparam logic [31:0] IDLE_RECIP  = 32'd2932031007;  // floor(2^40 / 375)
   localparam int          IDLE_SHIFT  = 40;
   localparam logic [31:0] STALE_RECIP = 32'd2199023255;  // floor(2^38 / 125)
   localparam int          STALE_SHIFT = 38;

   // Reciprocals for the triangle scaling: y / 150 and y / 2000
   localparam logic [16:0] IDLE_SCALE_RECIP  = 17'd111848;  // floor(2^24 / 150)
   localparam logic [17:0] STALE_SCALE_RECIP = 18'd134217;  // floor(2^28 / 2000)

   // Queue depths
   localparam int MIDQ_DEPTH = 4;
   localparam int MIDQ_AW    = $clog2(MIDQ_DEPTH);
   localparam int MIDQ_CW    = $clog2(MIDQ_DEPTH + 1);
   localparam int OUTQ_DEPTH = 16;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);
   localparam int PIPE_DEPTH = 6;
   localparam int PIPE_CW    = $clog2(PIPE_DEPTH + 1);

   // Channel beats
   typedef struct packed {
      logic [31:0] now_ms;
      logic [1:0]  display_mode;
      logic [7:0]  severity;
   } req_type;

   typedef struct packed {
      logic        clear_screen;
      logic        draw_valid;
      logic [6:0]  car_size;
      logic [15:0] car_color;
   } rsp_type;

   // Classified tick handed from front to back
   typedef struct packed {
      logic              clear;
      logic              draw;
      logic [1:0]        mode;
      logic [1:0]        sev_idx;
      logic              bright;
      logic [TIME_W-1:0] now;
   } work_type;

   function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   function automatic logic [TIME_W-1:0] alert_half(input logic [1:0] s);
      logic [TIME_W-1:0] h;
      unique case (s)
         2'd1:    h = TIME_W'(500);
         2'd2:    h = TIME_W'(250);
         default: h = TIME_W'(125);
      endcase
      return h;
   endfunction

   function automatic logic [6:0] alert_size(input logic [1:0] s);
      logic [6:0] z;
      unique case (s)
         2'd1:    z = 7'd70;
         2'd2:    z = 7'd80;
         default: z = 7'd90;
      endcase
      return z;
   endfunction

   function automatic logic [15:0] alert_color(input logic [1:0] s, input logic bright);
      logic [15:0] c;
      unique case ({bright, s})
         3'b101:  c = pack565(8'd220, 8'd30,  8'd0);
         3'b110:  c = pack565(8'd255, 8'd90,  8'd0);
         3'b111:  c = pack565(8'd255, 8'd220, 8'd0);
         3'b001:  c = pack565(8'd55,  8'd0,   8'd0);
         3'b010:  c = pack565(8'd70,  8'd15,  8'd0);
         default: c = pack565(8'd180, 8'd0,   8'd0);
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// File: sv/sca_front.sv
`default_nettype none

module sca_front
   import sca_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_item,
   output logic         req_full,
   output logic         head_valid,
   output work_type     head_work,
   input  wire logic    head_pop
);

   // Tick history and per-mode draw state
   logic [2:0]        prev_mode_ff, prev_mode_in;
   logic [7:0]        prev_sev_ff, prev_sev_in;
   logic [TIME_W-1:0] idle_ff, idle_in;
   logic [TIME_W-1:0] alert_ff, alert_in;
   logic [TIME_W-1:0] stale_ff, stale_in;
   logic              bright_ff, bright_in;

   // Queue toward the back end
   work_type          mem_ff [MIDQ_DEPTH];
   logic [MIDQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [MIDQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [MIDQ_CW-1:0] count_ff, count_in;

   logic              accept;
   logic              fresh;
   logic [TIME_W-1:0] now;
   logic [TIME_W-1:0] idle_eff, alert_eff, stale_eff;
   logic              bright_eff;
   logic              idle_go, alert_go, stale_go;
   logic [1:0]        sev_idx;
   logic              clear, draw;
   logic              push;
   work_type          work;

   assign req_full = (count_ff == MIDQ_CW'(MIDQ_DEPTH));
   assign accept   = req_push && !req_full;

   // Fresh test and elapsed-time checks; a fresh start zeroes the last draw
   always_comb begin
      now        = req_item.now_ms;
      fresh      = ({1'b0, req_item.display_mode} != prev_mode_ff) ||
                   (req_item.severity != prev_sev_ff);
      idle_eff   = fresh ? '0 : idle_ff;
      alert_eff  = fresh ? '0 : alert_ff;
      stale_eff  = fresh ? '0 : stale_ff;
      bright_eff = fresh || bright_ff;
      if (req_item.severity == 8'd0) begin
         sev_idx = 2'd1;
      end else if (req_item.severity > 8'd3) begin
         sev_idx = 2'd3;
      end else begin
         sev_idx = req_item.severity[1:0];
      end
      idle_go  = (now - idle_eff) >= IDLE_GAP;
      alert_go = (now - alert_eff) >= alert_half(sev_idx);
      stale_go = (now - stale_eff) >= STALE_GAP;
   end

   // Per-mode decision and state update
   always_comb begin
      clear        = 1'b0;
      draw         = 1'b0;
      idle_in      = idle_ff;
      alert_in     = alert_ff;
      stale_in     = stale_ff;
      bright_in    = bright_ff;
      prev_mode_in = prev_mode_ff;
      prev_sev_in  = prev_sev_ff;
      unique case (req_item.display_mode)
         MODE_IDLE: begin
            clear = fresh;
            draw  = idle_go;
            if (accept) begin
               idle_in = idle_go ? now : idle_eff;
            end
         end
         MODE_ALERT: begin
            clear = fresh;
            draw  = alert_go;
            if (accept) begin
               alert_in  = alert_go ? now : alert_eff;
               bright_in = alert_go ? !bright_eff : bright_eff;
            end
         end
         MODE_STALE: begin
            clear = fresh;
            draw  = stale_go;
            if (accept) begin
               stale_in = stale_go ? now : stale_eff;
            end
         end
         default: begin
         end
      endcase
      if (accept) begin
         prev_mode_in = {1'b0, req_item.display_mode};
         prev_sev_in  = req_item.severity;
      end
   end

   // Classified beat; ticks with no event are dropped here
   always_comb begin
      work.clear   = clear;
      work.draw    = draw;
      work.mode    = req_item.display_mode;
      work.sev_idx = sev_idx;
      work.bright  = bright_eff;
      work.now     = now;
      push         = accept && (clear || draw);
      wr_ptr_in    = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = head_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff + MIDQ_CW'(push) - MIDQ_CW'(head_pop);
   end

   assign head_valid = (count_ff != '0);
   assign head_work  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mode_ff <= PREV_MODE_RESET;
         prev_sev_ff  <= PREV_SEV_RESET;
         idle_ff      <= '0;
         alert_ff     <= '0;
         stale_ff     <= '0;
         bright_ff    <= 1'b1;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         prev_mode_ff <= prev_mode_in;
         prev_sev_ff  <= prev_sev_in;
         idle_ff      <= idle_in;
         alert_ff     <= alert_in;
         stale_ff     <= stale_in;
         bright_ff    <= bright_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= work;
      end
   end

endmodule

`default_nettype wire

// File: sv/sca_render.sv
`default_nettype none

module sca_render
   import sca_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire work_type            head_work,
   output logic                     head_pop,
   input  wire logic [OUTQ_CW-1:0]  outq_count,
   output logic                     res_valid,
   output rsp_type                  res_item
);

   typedef struct packed {
      work_type    work;
      logic [20:0] qi;
      logic [20:0] qs;
   } s1_type;

   typedef struct packed {
      work_type    work;
      logic [9:0]  ri;
      logic [7:0]  rs;
   } s2_type;

   typedef struct packed {
      work_type    work;
      logic        up_i;
      logic        up_s;
      logic [14:0] yi;
      logic [16:0] ys;
   } s3_type;

   typedef struct packed {
      work_type    work;
      logic        up_i;
      logic        up_s;
      logic [14:0] yi;
      logic [16:0] ys;
      logic [7:0]  qi;
      logic [6:0]  qs;
   } s4_type;

   typedef struct packed {
      work_type    work;
      logic        up_i;
      logic        up_s;
      logic [7:0]  off_i;
      logic [5:0]  off_s;
   } s5_type;

   logic [PIPE_DEPTH-1:0] v_ff, v_in;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   s5_type  s5_ff, s5_in;
   rsp_type s6_ff, s6_in;

   logic [PIPE_CW-1:0] inflight;
   logic [OUTQ_CW:0]   reserved;

   // Issue only when the output queue can hold every beat in flight
   always_comb begin
      inflight = PIPE_CW'($countones(v_ff));
      reserved = (OUTQ_CW+1)'(outq_count) + (OUTQ_CW+1)'(inflight);
      head_pop = head_valid && (reserved < (OUTQ_CW+1)'(OUTQ_DEPTH));
      v_in     = {v_ff[PIPE_DEPTH-2:0], head_pop};
   end

   // Stage 1: reciprocal multiply for the 375 and 125 quotients
   logic [60:0] prod_i;
   logic [58:0] prod_s;
   always_comb begin
      prod_i      = 61'(head_work.now[TIME_W-1:3]) * 61'(IDLE_RECIP);
      prod_s      = 59'(head_work.now[TIME_W-1:5]) * 59'(STALE_RECIP);
      s1_in.work  = head_work;
      s1_in.qi    = prod_i[IDLE_SHIFT+20:IDLE_SHIFT];
      s1_in.qs    = prod_s[STALE_SHIFT+20:STALE_SHIFT];
   end

   // Stage 2: remainders, off by at most one divisor
   logic [28:0] rem_i;
   logic [26:0] rem_s;
   always_comb begin
      rem_i      = s1_ff.work.now[TIME_W-1:3] - 29'(s1_ff.qi) * 29'd375;
      rem_s      = s1_ff.work.now[TIME_W-1:5] - 27'(s1_ff.qs) * 27'd125;
      s2_in.work = s1_ff.work;
      s2_in.ri   = rem_i[9:0];
      s2_in.rs   = rem_s[7:0];
   end

   // Stage 3: phase within the period, half select, scale numerator
   logic [9:0]  ri_fix;
   logic [7:0]  rs_fix;
   logic [11:0] ph_i, ph_s;
   logic [10:0] off_i, off_s;
   always_comb begin
      ri_fix      = (s2_ff.ri >= 10'd375) ? s2_ff.ri - 10'd375 : s2_ff.ri;
      rs_fix      = (s2_ff.rs >= 8'd125) ? s2_ff.rs - 8'd125 : s2_ff.rs;
      ph_i        = {ri_fix[8:0], s2_ff.work.now[2:0]};
      ph_s        = {rs_fix[6:0], s2_ff.work.now[4:0]};
      s3_in.up_i  = ph_i < 12'd1500;
      s3_in.up_s  = ph_s < 12'd2000;
      off_i       = s3_in.up_i ? ph_i[10:0] : 11'(ph_i - 12'd1500);
      off_s       = s3_in.up_s ? ph_s[10:0] : 11'(ph_s - 12'd2000);
      s3_in.yi    = 15'(off_i) * 15'd17;
      s3_in.ys    = 17'(off_s) * 17'd43;
      s3_in.work  = s2_ff.work;
   end

   // Stage 4: reciprocal multiply for y / 150 and y / 2000
   logic [31:0] sc_i;
   logic [34:0] sc_s;
   always_comb begin
      sc_i       = 32'(s3_ff.yi) * 32'(IDLE_SCALE_RECIP);
      sc_s       = 35'(s3_ff.ys) * 35'(STALE_SCALE_RECIP);
      s4_in.work = s3_ff.work;
      s4_in.up_i = s3_ff.up_i;
      s4_in.up_s = s3_ff.up_s;
      s4_in.yi   = s3_ff.yi;
      s4_in.ys   = s3_ff.ys;
      s4_in.qi   = sc_i[31:24];
      s4_in.qs   = sc_s[34:28];
   end

   // Stage 5: quotient correction
   logic [14:0] r2_i;
   logic [16:0] r2_s;
   always_comb begin
      r2_i        = s4_ff.yi - 15'(s4_ff.qi) * 15'd150;
      r2_s        = s4_ff.ys - 17'(s4_ff.qs) * 17'd2000;
      s5_in.work  = s4_ff.work;
      s5_in.up_i  = s4_ff.up_i;
      s5_in.up_s  = s4_ff.up_s;
      s5_in.off_i = s4_ff.qi + 8'(r2_i >= 15'd150);
      s5_in.off_s = 6'(s4_ff.qs) + 6'(r2_s >= 17'd2000);
   end

   // Stage 6: brightness, colour packing and result select
   logic [7:0]  b_i;
   logic [5:0]  b_s;
   logic [17:0] g_prod;
   logic [7:0]  g_i;
   always_comb begin
      b_i    = s5_ff.up_i ? 8'd30 + s5_ff.off_i : 8'd200 - s5_ff.off_i;
      b_s    = s5_ff.up_s ? 6'd12 + s5_ff.off_s : 6'd55 - s5_ff.off_s;
      g_prod = 18'(b_i) * 18'd820;   // 4b/5 as 4b * 205 >> 10
      g_i    = g_prod[17:10];
      s6_in.clear_screen = s5_ff.work.clear;
      s6_in.draw_valid   = s5_ff.work.draw;
      s6_in.car_size     = '0;
      s6_in.car_color    = '0;
      if (s5_ff.work.draw) begin
         case (s5_ff.work.mode)
            MODE_IDLE: begin
               s6_in.car_size  = IDLE_SIZE;
               s6_in.car_color = pack565(8'd0, g_i, b_i);
            end
            MODE_ALERT: begin
               s6_in.car_size  = alert_size(s5_ff.work.sev_idx);
               s6_in.car_color = alert_color(s5_ff.work.sev_idx, s5_ff.work.bright);
            end
            default: begin
               s6_in.car_size  = STALE_SIZE;
               s6_in.car_color = pack565(8'(b_s[5:2]), 8'(b_s[5:2]), 8'(b_s));
            end
         endcase
      end
   end

   assign res_valid = v_ff[PIPE_DEPTH-1];
   assign res_item  = s6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      s5_ff <= s5_in;
      s6_ff <= s6_in;
   end

endmodule

`default_nettype wire

// File: sv/sca_outq.sv
`default_nettype none

module sca_outq
   import sca_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                res_valid,
   input  wire rsp_type             res_item,
   output logic [OUTQ_CW-1:0]       outq_count,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output rsp_type                  rsp_item
);

   rsp_type             mem_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CW-1:0]  count_ff, count_in;
   logic                take;

   // Pointer and fill bookkeeping; space is reserved upstream
   always_comb begin
      take      = rsp_pop && !rsp_empty;
      wr_ptr_in = res_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + OUTQ_CW'(res_valid) - OUTQ_CW'(take);
   end

   assign rsp_empty  = (count_ff == '0);
   assign rsp_item   = mem_ff[rd_ptr_ff];
   assign outq_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         mem_ff[wr_ptr_ff] <= res_item;
      end
   end

endmodule

`default_nettype wire

// File: sv/status_car_animation_sequencer.sv
// Channel   Ports                          Beat moves on
// -------   -----------------------------  ---------------------------
// request   req_push req_full req_item     req_push & !req_full
// response  rsp_empty rsp_pop rsp_item     rsp_pop & !rsp_empty
//
// One tick is taken per cycle while req_full is low; the front end decides
// fresh/clear/draw and updates the tick mode's draw state on acceptance.
// Ticks with an event wait in the middle queue, then run a 6-stage colour
// pipeline (two reciprocal multiply, correct rounds) into a 16-entry
// result queue. Ticks without an event give no beat.
// Reset is synchronous and empties both queues and the pipeline.
// A stalled response side fills the result queue, then the 4-entry
// middle queue, and only then raises req_full.
`default_nettype none

module status_car_animation_sequencer
   import sca_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_item,
   output logic         req_full,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_item
);

   logic               head_valid;
   work_type           head_work;
   logic               head_pop;
   logic [OUTQ_CW-1:0] outq_count;
   logic               res_valid;
   rsp_type            res_item;

   sca_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_item   (req_item),
      .req_full   (req_full),
      .head_valid (head_valid),
      .head_work  (head_work),
      .head_pop   (head_pop)
   );

   sca_render u_render (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_work  (head_work),
      .head_pop   (head_pop),
      .outq_count (outq_count),
      .res_valid  (res_valid),
      .res_item   (res_item)
   );

   sca_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_item   (res_item),
      .outq_count (outq_count),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// File: sv/sca_checker.sv
`default_nettype none

module sca_checker
   import sca_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_full,
   input  wire logic    rsp_empty,
   input  wire logic    rsp_pop,
   input  wire rsp_type rsp_item
);

   // A response beat always carries a clear or a draw
   a_beat_has_event: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_item.clear_screen || rsp_item.draw_valid))
      else $error("response beat with neither clear nor draw");

   // Clear-only beats carry zero size and colour
   a_clear_only_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_item.draw_valid) |->
         (rsp_item.car_size == 7'd0 && rsp_item.car_color == 16'd0))
      else $error("clear-only beat with nonzero payload");

   // Drawn sizes come from the mode tables
   a_size_legal: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.draw_valid) |->
         (rsp_item.car_size == IDLE_SIZE || rsp_item.car_size == STALE_SIZE ||
          rsp_item.car_size == 7'd70 || rsp_item.car_size == 7'd80 ||
          rsp_item.car_size == 7'd90))
      else $error("drawn beat with illegal car size");

   // The result queue is empty and req_full is low when reset drops
   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> (rsp_empty && !req_full))
      else $error("queue not empty after reset");

   // A stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("stalled response beat changed");

endmodule

bind status_car_animation_sequencer sca_checker u_sca_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_item  (rsp_item)
);

`default_nettype wire
